/* rtl/lz_window_token_decoder_assert.svh */
// Assertion macros shared by the decoder modules.
`ifndef LZ_WINDOW_TOKEN_DECODER_ASSERT_SVH
`define LZ_WINDOW_TOKEN_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define LZWD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define LZWD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) ante |=> cons) else $error(msg);
`else
`define LZWD_ASSERT(lbl, prop, msg)
`define LZWD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/lzwd_pkg.sv */
package lzwd_pkg;

   localparam int HIST_AW    = 12;
   localparam int HIST_DEPTH = 1 << HIST_AW;

   localparam int CSR_AW = 4;

   localparam logic [1:0] REG_DECODED_SIZE  = 2'd0;
   localparam logic [1:0] REG_SKIP_COUNT    = 2'd1;
   localparam logic [1:0] REG_OUTPUT_LENGTH = 2'd2;

   localparam logic [31:0] OUTPUT_LENGTH_RESET = 32'd1;

   localparam logic [11:0] DIST_MASK       = 12'hFFF;
   localparam logic [8:0]  LONG_COUNT_BIAS = 9'h12;
   localparam logic [8:0]  SHORT_COUNT_BIAS = 9'd2;
   localparam logic [3:0]  LANES           = 4'd8;

   typedef struct packed {
      logic [31:0] decoded_size;
      logic [31:0] skip_count;
      logic [31:0] output_length;
      logic        skip_we;
      logic        length_we;
      logic [31:0] wdata;
   } cfg_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] data;
      logic       flush_valid;
      logic       last;
      logic       err;
   } pack_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic lanes_full;
   } pack_status_type;

endpackage

/* rtl/lzwd_ram.sv */
module lzwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lzwd_packer.sv */
`include "lz_window_token_decoder_assert.svh"

module lzwd_packer (
   input  logic                     clock,
   input  logic                     reset,
   input  lzwd_pkg::pack_cmd_type    cmd,
   output lzwd_pkg::pack_status_type status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [63:0]              rsp_out_bytes,
   output logic [3:0]               rsp_byte_count,
   output logic                     rsp_last,
   output logic                     rsp_error
);
   import lzwd_pkg::*;

   logic [7:0]  lane_ff [8];
   logic [7:0]  lane_in [8];
   logic [3:0]  fill_ff;
   logic [3:0]  fill_in;
   logic        valid_ff;
   logic        valid_in;
   logic [63:0] bytes_ff;
   logic [63:0] bytes_in;
   logic [3:0]  count_ff;
   logic [3:0]  count_in;
   logic        last_ff;
   logic        last_in;
   logic        err_ff;
   logic        err_in;
   logic        slot_free;
   logic        push;
   logic [63:0] lane_word;

   assign slot_free = !valid_ff || !rsp_stall;
   assign status.slot_free  = slot_free;
   assign status.lanes_full = (fill_ff == LANES);

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         lane_word[8*k +: 8] = lane_ff[k];
      end
   end

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         lane_in[k] = lane_ff[k];
      end
      fill_in  = fill_ff;
      push     = 1'b0;
      bytes_in = bytes_ff;
      count_in = count_ff;
      last_in  = last_ff;
      err_in   = err_ff;

      if (cmd.byte_valid) begin
         if (fill_ff == LANES) begin
            // A full group is held until a further byte shows it is not the last, or until a flush sends it.
            push     = 1'b1;
            bytes_in = lane_word;
            count_in = LANES;
            last_in  = 1'b0;
            err_in   = 1'b0;
            for (int k = 0; k < 8; k++) begin
               lane_in[k] = 8'd0;
            end
            lane_in[0] = cmd.data;
            fill_in    = 4'd1;
         end else begin
            lane_in[fill_ff[2:0]] = cmd.data;
            fill_in               = fill_ff + 4'd1;
         end
      end else if (cmd.flush_valid) begin
         if (fill_ff != 4'd0 || cmd.last) begin
            push     = 1'b1;
            bytes_in = lane_word;
            count_in = fill_ff;
            last_in  = cmd.last;
            err_in   = cmd.err;
         end
         for (int k = 0; k < 8; k++) begin
            lane_in[k] = 8'd0;
         end
         fill_in = 4'd0;
      end

      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_stall) begin
         valid_in = valid_ff;
      end else begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 8; k++) begin
            lane_ff[k] <= 8'd0;
         end
         fill_ff  <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         lane_ff  <= lane_in;
         fill_ff  <= fill_in;
         valid_ff <= valid_in;
      end
      if (push) begin
         bytes_ff <= bytes_in;
         count_ff <= count_in;
         last_ff  <= last_in;
         err_ff   <= err_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_bytes  = bytes_ff;
   assign rsp_byte_count = count_ff;
   assign rsp_last       = last_ff;
   assign rsp_error      = err_ff;

   `LZWD_ASSERT(a_fill_range, (fill_ff <= LANES), "lane fill exceeds eight")
   `LZWD_ASSERT(a_push_has_room, (push |-> slot_free), "result pushed over a held result")
   `LZWD_ASSERT(a_empty_is_last, (valid_ff |-> (count_ff != 4'd0 || last_ff)),
                "empty result without last")

endmodule

/* rtl/lzwd_ctrl.sv */
`include "lz_window_token_decoder_assert.svh"

module lzwd_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_is_literal,
   input  logic [7:0]                    req_data_byte,
   input  logic [15:0]                   req_link_word,
   input  lzwd_pkg::cfg_type             cfg,
   output logic                          ram_wr_en,
   output logic [lzwd_pkg::HIST_AW-1:0]  ram_wr_addr,
   output logic [7:0]                    ram_wr_data,
   output logic                          ram_rd_en,
   output logic [lzwd_pkg::HIST_AW-1:0]  ram_rd_addr,
   input  logic [7:0]                    ram_rd_data,
   output lzwd_pkg::pack_cmd_type        pack_cmd,
   input  lzwd_pkg::pack_status_type     pack_status
);
   import lzwd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LIT,
      ST_CALC,
      ST_RD,
      ST_WR,
      ST_FLUSH
   } state_type;

   state_type    state_ff;
   state_type    state_in;
   logic [31:0]  pos_ff;
   logic [31:0]  pos_in;
   logic [31:0]  skip_left_ff;
   logic [31:0]  skip_left_in;
   logic [31:0]  emit_left_ff;
   logic [31:0]  emit_left_in;
   logic         finished_ff;
   logic         finished_in;
   logic         done_ff;
   logic         done_in;
   logic         err_ff;
   logic         err_in;
   logic [7:0]   data_ff;
   logic [7:0]   data_in;
   logic [15:0]  link_ff;
   logic [15:0]  link_in;
   logic [8:0]   count_ff;
   logic [8:0]   count_in;

   logic [8:0]   raw_count;
   logic [31:0]  room;
   logic [12:0]  copy_dist;
   logic [7:0]   next_byte;
   logic         byte_blocked;
   logic         window_bad;
   logic         flush_last;

   assign copy_dist = {1'b0, link_ff[11:0] & DIST_MASK} + 13'd1;
   assign raw_count = (link_ff[15:12] == 4'd0) ? ({1'b0, data_ff} + LONG_COUNT_BIAS)
                                               : ({5'd0, link_ff[15:12]} + SHORT_COUNT_BIAS);
   assign room = cfg.decoded_size - pos_ff;
   assign next_byte = (state_ff == ST_LIT) ? data_ff : ram_rd_data;
   assign byte_blocked = (skip_left_ff == 32'd0) && pack_status.lanes_full
                         && !pack_status.slot_free;
   assign window_bad = (cfg.output_length == 32'd0) || (cfg.skip_count > cfg.decoded_size)
                       || (emit_left_ff == 32'd0);
   assign flush_last = done_ff || (pos_ff >= cfg.decoded_size);
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      skip_left_in = skip_left_ff;
      emit_left_in = emit_left_ff;
      finished_in  = finished_ff;
      done_in      = done_ff;
      err_in       = err_ff;
      data_in      = data_ff;
      link_in      = link_ff;
      count_in     = count_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pos_ff[HIST_AW-1:0];
      ram_wr_data  = next_byte;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = pos_ff[HIST_AW-1:0] - HIST_AW'(copy_dist);
      pack_cmd     = '0;
      pack_cmd.data = next_byte;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !finished_ff) begin
               data_in = req_data_byte;
               link_in = req_link_word;
               done_in = 1'b0;
               err_in  = 1'b0;
               if (window_bad) begin
                  done_in  = 1'b1;
                  err_in   = 1'b1;
                  state_in = ST_FLUSH;
               end else if (req_is_literal) begin
                  state_in = ST_LIT;
               end else begin
                  state_in = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            if (pos_ff >= cfg.decoded_size) begin
               count_in = 9'd0;
            end else if (room < {23'd0, raw_count}) begin
               count_in = room[8:0];
            end else begin
               count_in = raw_count;
            end
            state_in = ST_RD;
         end
         ST_RD: begin
            if (count_ff == 9'd0 || done_ff) begin
               state_in = ST_FLUSH;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_WR;
            end
         end
         ST_LIT, ST_WR: begin
            if (!byte_blocked) begin
               ram_wr_en = 1'b1;
               pos_in    = pos_ff + 32'd1;
               if (skip_left_ff != 32'd0) begin
                  skip_left_in = skip_left_ff - 32'd1;
               end else begin
                  pack_cmd.byte_valid = 1'b1;
                  emit_left_in        = emit_left_ff - 32'd1;
                  if (emit_left_ff == 32'd1) begin
                     done_in = 1'b1;
                  end
               end
               if (state_ff == ST_LIT) begin
                  state_in = ST_FLUSH;
               end else begin
                  count_in = count_ff - 9'd1;
                  state_in = ST_RD;
               end
            end
         end
         ST_FLUSH: begin
            if (pack_status.slot_free) begin
               pack_cmd.flush_valid = 1'b1;
               pack_cmd.last        = flush_last;
               pack_cmd.err         = err_ff;
               if (flush_last) begin
                  finished_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg.skip_we) begin
         skip_left_in = cfg.wdata;
      end
      if (cfg.length_we) begin
         emit_left_in = cfg.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= 32'd0;
         skip_left_ff <= 32'd0;
         emit_left_ff <= OUTPUT_LENGTH_RESET;
         finished_ff  <= 1'b0;
         done_ff      <= 1'b0;
         err_ff       <= 1'b0;
         count_ff     <= 9'd0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         skip_left_ff <= skip_left_in;
         emit_left_ff <= emit_left_in;
         finished_ff  <= finished_in;
         done_ff      <= done_in;
         err_ff       <= err_in;
         count_ff     <= count_in;
      end
      data_ff <= data_in;
      link_ff <= link_in;
   end

   `LZWD_ASSERT(a_copy_has_count, ((state_ff == ST_WR) |-> (count_ff != 9'd0)),
                "copy step entered with no bytes left")
   `LZWD_ASSERT(a_skip_before_emit, (pack_cmd.byte_valid |-> (skip_left_ff == 32'd0)),
                "byte emitted while still skipping")
   `LZWD_ASSERT(a_finish_from_flush, ($rose(finished_ff) |-> $past(state_ff == ST_FLUSH)),
                "decode finished outside the flush step")
   `LZWD_ASSERT_NEXT(a_read_then_write, (state_ff == ST_RD && ram_rd_en),
                     (state_ff == ST_WR), "history read not followed by its write")

endmodule

/* rtl/lz_window_token_decoder.sv */
// Yay0 token decoder with an output window. Each request carries one token that a front end has
// split from the stream; literals produce one byte and back-references copy bytes from a
// 4096-byte history RAM. The first skip_count decoded bytes are dropped, then output_length bytes
// are sent out packed up to eight per result, first byte in the lowest lane; last marks the end
// of the decode and error flags an invalid window. A literal passes through the literal and flush
// states; a back-reference passes through a count step, a read and a write step per copied byte,
// and the flush, as each byte is read through the single registered read port of the history RAM
// and written back before the next. No further request is accepted until the current token
// has been flushed; a stalled result holds the decoder when a byte must push a full group, and
// at each flush. The history is not cleared after reset: a back-reference to bytes not yet
// decoded returns undefined data. Configuration is to be written through the APB port while
// idle, unenforced by the block; writing skip_count or output_length reloads its window counter.
module lz_window_token_decoder (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_is_literal,
   input  logic [7:0]                   req_data_byte,
   input  logic [15:0]                  req_link_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [63:0]                  rsp_out_bytes,
   output logic [3:0]                   rsp_byte_count,
   output logic                         rsp_last,
   output logic                         rsp_error,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [lzwd_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import lzwd_pkg::*;

   logic [31:0]     decoded_size_ff;
   logic [31:0]     skip_count_ff;
   logic [31:0]     output_length_ff;
   logic            csr_write;
   logic [1:0]      csr_index;
   cfg_type         cfg;
   pack_cmd_type    pack_cmd;
   pack_status_type pack_status;
   logic            ram_wr_en;
   logic [HIST_AW-1:0] ram_wr_addr;
   logic [7:0]      ram_wr_data;
   logic            ram_rd_en;
   logic [HIST_AW-1:0] ram_rd_addr;
   logic [7:0]      ram_rd_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         decoded_size_ff  <= 32'd0;
         skip_count_ff    <= 32'd0;
         output_length_ff <= OUTPUT_LENGTH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_DECODED_SIZE:  decoded_size_ff  <= csr_pwdata;
            REG_SKIP_COUNT:    skip_count_ff    <= csr_pwdata;
            REG_OUTPUT_LENGTH: output_length_ff <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_DECODED_SIZE:  csr_prdata = decoded_size_ff;
         REG_SKIP_COUNT:    csr_prdata = skip_count_ff;
         REG_OUTPUT_LENGTH: csr_prdata = output_length_ff;
         default:           csr_prdata = 32'd0;
      endcase
   end

   assign cfg.decoded_size  = decoded_size_ff;
   assign cfg.skip_count    = skip_count_ff;
   assign cfg.output_length = output_length_ff;
   assign cfg.skip_we       = csr_write && (csr_index == REG_SKIP_COUNT);
   assign cfg.length_we     = csr_write && (csr_index == REG_OUTPUT_LENGTH);
   assign cfg.wdata         = csr_pwdata;

   lzwd_ram #(
      .WIDTH (8),
      .DEPTH (HIST_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lzwd_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_is_literal (req_is_literal),
      .req_data_byte  (req_data_byte),
      .req_link_word  (req_link_word),
      .cfg            (cfg),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .pack_cmd       (pack_cmd),
      .pack_status    (pack_status)
   );

   lzwd_packer u_packer (
      .clock          (clock),
      .reset          (reset),
      .cmd            (pack_cmd),
      .status         (pack_status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_bytes  (rsp_out_bytes),
      .rsp_byte_count (rsp_byte_count),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error)
   );

endmodule
